// ===== design/pidm_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared types, register map and fixed constants of the PID controller.
// ----------------------------------------------------------------------------
package pidm_pkg;

    // APB register port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register indexes, taken from paddr[4:2].
    localparam logic [REG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_OUT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INT_LIMIT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LOOP_MODE = 3'd6;

    // Loop mode codes; the unused code behaves as normal mode.
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [1:0] MODE_ORIENT   = 2'd2;

    // Straight-mode deadband and orientation-mode derivative gate.
    localparam int DEADBAND_LIMIT = 10;
    localparam int ORIENT_GATE    = 40;

    // Reset values of the clamp registers.
    localparam logic [14:0] MAX_OUT_RESET   = 15'h7FFF;
    localparam logic [14:0] INT_LIMIT_RESET = 15'h7FFF;

    // Configuration set handed from the register file to the datapath.
    typedef struct packed {
        logic signed [15:0] target_value;
        logic        [14:0] max_output;
        logic        [14:0] integral_limit;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic        [1:0]  loop_mode;
    } t_cfg;

endpackage

// ===== design/pidm_meas_if.sv =====
// ----------------------------------------------------------------------------
// Measurement channel
// Valid/ready channel that carries one measured sample per transaction.
// ----------------------------------------------------------------------------
interface pidm_meas_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measure;

    modport source (output valid, output measure, input ready);
    modport sink   (input valid, input measure, output ready);
endinterface

// ===== design/pidm_drive_if.sv =====
// ----------------------------------------------------------------------------
// Drive channel
// Valid/ready channel that carries one controller output per transaction.
// ----------------------------------------------------------------------------
interface pidm_drive_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/pid_controller_with_modes.sv =====
// A sample passes the input, error, product, integral, sum and output stages.
// Throughput: one sample per cycle; the six-register pipeline advances as a
// whole and holds while the output register waits for the consumer.
// Loop state is updated in one stage each, so samples may go back to back.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the loop state
// and returns the registers to their reset values.
// ----------------------------------------------------------------------------
// PID controller with loop modes
// Positional PID regulator with straight deadband and orientation gating.
// ----------------------------------------------------------------------------
module pid_controller_with_modes (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pidm_meas_if.sink                       i_meas,
    pidm_drive_if.source                    o_drive,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pidm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pidm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pidm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    pidm_pkg::t_cfg w_cfg;

    // Configuration registers.
    pidm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Control datapath.
    pidm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_meas.valid),
        .o_ready   (i_meas.ready),
        .i_measure (i_meas.measure),
        .o_valid   (o_drive.valid),
        .i_ready   (o_drive.ready),
        .o_drive   (o_drive.drive)
    );

endmodule

// ===== design/pidm_regs.sv =====
// ----------------------------------------------------------------------------
// PID controller register file
// APB-style register block holding setpoint, clamps, gains and loop mode.
// ----------------------------------------------------------------------------
module pidm_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pidm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pidm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pidm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output pidm_pkg::t_cfg                   o_cfg
);

    pidm_pkg::t_cfg                   r_cfg;
    logic                             w_wr_en;
    logic [pidm_pkg::REG_IDX_W-1:0]   w_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign w_wr_en = psel && penable && pwrite && pready;
    assign w_idx   = paddr[pidm_pkg::APB_ADDR_W-1:2];

    // Register writes; an index beyond the map is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_value   <= '0;
            r_cfg.max_output     <= pidm_pkg::MAX_OUT_RESET;
            r_cfg.integral_limit <= pidm_pkg::INT_LIMIT_RESET;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.loop_mode      <= pidm_pkg::MODE_NORMAL;
        end else if (w_wr_en) begin
            case (w_idx)
                pidm_pkg::REG_TARGET:    r_cfg.target_value   <= $signed(pwdata[15:0]);
                pidm_pkg::REG_MAX_OUT:   r_cfg.max_output     <= pwdata[14:0];
                pidm_pkg::REG_INT_LIMIT: r_cfg.integral_limit <= pwdata[14:0];
                pidm_pkg::REG_GAIN_P:    r_cfg.gain_p         <= $signed(pwdata[15:0]);
                pidm_pkg::REG_GAIN_I:    r_cfg.gain_i         <= $signed(pwdata[15:0]);
                pidm_pkg::REG_GAIN_D:    r_cfg.gain_d         <= $signed(pwdata[15:0]);
                pidm_pkg::REG_LOOP_MODE: r_cfg.loop_mode      <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data; signed registers are sign extended.
    always_comb begin
        case (w_idx)
            pidm_pkg::REG_TARGET:    prdata = 32'(r_cfg.target_value);
            pidm_pkg::REG_MAX_OUT:   prdata = {17'd0, r_cfg.max_output};
            pidm_pkg::REG_INT_LIMIT: prdata = {17'd0, r_cfg.integral_limit};
            pidm_pkg::REG_GAIN_P:    prdata = 32'(r_cfg.gain_p);
            pidm_pkg::REG_GAIN_I:    prdata = 32'(r_cfg.gain_i);
            pidm_pkg::REG_GAIN_D:    prdata = 32'(r_cfg.gain_d);
            pidm_pkg::REG_LOOP_MODE: prdata = {30'd0, r_cfg.loop_mode};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/pidm_core.sv =====
// ----------------------------------------------------------------------------
// PID controller datapath
// Pipelined error, product, integral, sum and clamp stages with stall control.
// ----------------------------------------------------------------------------
module pidm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pidm_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_measure,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_drive
);

    // Stage valids: input register, error, products, integral, sum, output.
    logic               r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic               w_en;

    // Loop state.
    logic signed [16:0] r_prev_err;
    logic signed [23:0] r_integ;

    // Stage payloads.
    logic signed [15:0] r_meas0;
    logic signed [16:0] r_err1;
    logic signed [17:0] r_diff1;
    logic               r_dead1, r_dead2, r_dead3, r_dead4;
    logic signed [32:0] r_pterm2, r_iprod2;
    logic signed [33:0] r_dterm2;
    logic signed [34:0] r_pd3;
    logic signed [23:0] r_isum3;
    logic signed [35:0] r_sum4;
    logic signed [15:0] r_drive5;

    // Combinational stage results.
    logic signed [16:0] n_err;
    logic               n_dead, n_gate;
    logic signed [17:0] n_diff;
    logic signed [33:0] n_isum, w_lim;
    logic signed [23:0] n_integ;
    logic signed [27:0] w_quot, w_maxo, n_trunc;
    logic               w_round;
    logic signed [15:0] n_drive;

    // The whole pipeline advances together unless a result waits downstream.
    assign w_en    = !r_v5 || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v5;
    assign o_drive = r_drive5;

    // Stage 1: error, deadband and derivative gate.
    always_comb begin
        n_err  = 17'(i_cfg.target_value) - 17'(r_meas0);
        n_dead = (i_cfg.loop_mode == pidm_pkg::MODE_STRAIGHT)
                 && (n_err > -17'(pidm_pkg::DEADBAND_LIMIT))
                 && (n_err < 17'(pidm_pkg::DEADBAND_LIMIT));
        n_gate = (i_cfg.loop_mode == pidm_pkg::MODE_ORIENT)
                 && (n_err >= 17'(pidm_pkg::ORIENT_GATE));
        n_diff = n_gate ? '0 : (18'(n_err) - 18'(r_prev_err));
    end

    // Stage 3: integral accumulation with symmetric clamp.
    always_comb begin
        w_lim  = $signed({11'd0, i_cfg.integral_limit, 8'd0});
        n_isum = 34'(r_integ) + 34'(r_iprod2);
        if (n_isum > w_lim) begin
            n_integ = 24'(w_lim);
        end else if (n_isum < -w_lim) begin
            n_integ = 24'(-w_lim);
        end else begin
            n_integ = 24'(n_isum);
        end
    end

    // Output stage: truncate toward zero, then clamp to the drive limit.
    always_comb begin
        w_quot  = r_sum4[35:8];
        w_round = r_sum4[35] && (r_sum4[7:0] != 8'd0);
        n_trunc = w_quot + 28'(w_round);
        w_maxo  = $signed({13'd0, i_cfg.max_output});
        if (r_dead4) begin
            n_drive = '0;
        end else if (n_trunc > w_maxo) begin
            n_drive = 16'(w_maxo);
        end else if (n_trunc < -w_maxo) begin
            n_drive = 16'(-w_maxo);
        end else begin
            n_drive = 16'(n_trunc);
        end
    end

    // Control state and loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_v5       <= 1'b0;
            r_prev_err <= '0;
            r_integ    <= '0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (r_v0 && !n_dead) begin
                r_prev_err <= n_err;
            end
            if (r_v2 && !r_dead2) begin
                r_integ <= n_integ;
            end
        end
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meas0  <= i_measure;
            r_err1   <= n_err;
            r_diff1  <= n_diff;
            r_dead1  <= n_dead;
            r_pterm2 <= 33'(r_err1) * 33'(i_cfg.gain_p);
            r_iprod2 <= 33'(r_err1) * 33'(i_cfg.gain_i);
            r_dterm2 <= 34'(r_diff1) * 34'(i_cfg.gain_d);
            r_dead2  <= r_dead1;
            r_pd3    <= 35'(r_pterm2) + 35'(r_dterm2);
            r_isum3  <= n_integ;
            r_dead3  <= r_dead2;
            r_sum4   <= 36'(r_pd3) + 36'(r_isum3);
            r_dead4  <= r_dead3;
            r_drive5 <= n_drive;
        end
    end

endmodule

// ===== design/pidm_checker.sv =====
// ----------------------------------------------------------------------------
// PID controller port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module pidm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_drive_valid,
    input logic               i_drive_ready,
    input logic signed [15:0] i_drive,
    input logic               i_pready
);

    // A drive transaction, once offered, stays offered until taken.
    a_drive_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_drive_valid && !i_drive_ready |=> i_drive_valid)
        else $error("drive valid dropped before transaction");

    // A stalled drive value does not change.
    a_drive_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_drive_valid && !i_drive_ready |=> $stable(i_drive))
        else $error("drive changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_drive_valid)
        else $error("drive valid after reset");

    // The symmetric clamp never reaches the most negative code.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_drive_valid |-> i_drive != 16'sh8000)
        else $error("drive outside the symmetric clamp range");

    // The register port never stalls.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind pid_controller_with_modes pidm_checker u_pidm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_drive_valid (o_drive.valid),
    .i_drive_ready (o_drive.ready),
    .i_drive       (o_drive.drive),
    .i_pready      (pready)
);

// ===== verif/pid_controller_with_modes_test.sv =====
// ----------------------------------------------------------------------------
// PID controller with loop modes testbench
// Writes the register set over APB, then streams measured samples into the
// controller under random idling on both channels. A predictor in the
// testbench computes the expected drive for each sample. Every drive
// transaction is checked against the oldest expected value.
// ----------------------------------------------------------------------------
module pid_controller_with_modes_test;
    import pidm_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [1:0]           MODE_UNUSED  = 2'd3;

    localparam int QUIET_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_SAMPLES   = 205;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int BURST_SAMPLES   = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pidm_meas_if  meas_if();
    pidm_drive_if drive_if();

    // Shadow copy of the registers and of the loop state.
    t_cfg               cfg_shadow;
    logic signed [16:0] last_error;
    logic signed [23:0] integral_acc;

    // Expected drive values, oldest first.
    logic signed [15:0] drive_expect_q[$];

    int error_count;
    bit no_idle;
    int hold_cycles;

    pid_controller_with_modes u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas_if),
        .o_drive (drive_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Gap length in cycles: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Samples cluster around the setpoint so that the deadband and the
    // derivative gate are crossed often; the rest are extremes or anything.
    function automatic logic signed [15:0] pick_measure();
        int          r;
        logic [31:0] raw;
        r   = $urandom_range(0, 99);
        raw = $urandom();
        if (r < 30) begin
            raw = int'($signed(cfg_shadow.target_value)) + 60 - $urandom_range(0, 120);
        end else if (r < 40) begin
            case ($urandom_range(0, 3))
                0: raw = 32'h0000_8000;
                1: raw = 32'h0000_7FFF;
                2: raw = 32'h0000_0000;
                default: raw = 32'hFFFF_FFFF;
            endcase
        end
        return raw[15:0];
    endfunction

    // Q8.8 gain: often moderate so the output is not always saturated.
    function automatic logic [15:0] pick_gain();
        int          r;
        logic [31:0] raw;
        r   = $urandom_range(0, 99);
        raw = $urandom();
        if (r < 45) begin
            raw = $urandom_range(0, 1024) - 512;
        end else if (r < 60) begin
            case ($urandom_range(0, 3))
                0: raw = 32'h0000_8000;
                1: raw = 32'h0000_7FFF;
                2: raw = 32'h0000_0000;
                default: raw = 32'h0000_0100;
            endcase
        end
        return raw[15:0];
    endfunction

    // Clamp limit for drive and integral.
    function automatic logic [14:0] pick_limit();
        int          r;
        logic [31:0] raw;
        r = $urandom_range(0, 99);
        if (r < 15) raw = 0;
        else if (r < 30) raw = 32767;
        else if (r < 70) raw = $urandom_range(1, 2000);
        else raw = $urandom_range(0, 32767);
        return raw[14:0];
    endfunction

    function automatic logic [15:0] pick_target();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: raw = 32'h0000_8000;
            1: raw = 32'h0000_7FFF;
            2: raw = 32'h0000_0000;
            default: ;
        endcase
        return raw[15:0];
    endfunction

    // Advance the loop state by one sample and return the expected drive.
    function automatic logic signed [15:0] pid_step(input logic signed [15:0] sample);
        longint err;
        longint pterm;
        longint dterm;
        longint lim;
        longint acc;
        longint total;
        longint res;
        longint maxo;
        err = longint'($signed(cfg_shadow.target_value)) - longint'(sample);

        // Inside the straight-mode deadband the state is left alone.
        if (cfg_shadow.loop_mode == MODE_STRAIGHT &&
                err > -DEADBAND_LIMIT && err < DEADBAND_LIMIT) begin
            return '0;
        end

        pterm = err * longint'($signed(cfg_shadow.gain_p));
        if (cfg_shadow.loop_mode == MODE_ORIENT && err >= ORIENT_GATE) begin
            dterm = 0;
        end else begin
            dterm = (err - longint'(last_error)) * longint'($signed(cfg_shadow.gain_d));
        end

        // Integral accumulates in Q.8 and is clamped to the limit.
        lim = longint'(cfg_shadow.integral_limit) * 256;
        acc = longint'(integral_acc) + err * longint'($signed(cfg_shadow.gain_i));
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        integral_acc = acc[23:0];
        last_error   = err[16:0];

        // Truncate toward zero, then clamp to the output limit.
        total = pterm + acc + dterm;
        res   = (total < 0) ? -((-total) >>> 8) : (total >>> 8);
        maxo  = longint'(cfg_shadow.max_output);
        if (res > maxo) res = maxo;
        else if (res < -maxo) res = -maxo;
        return res[15:0];
    endfunction

    task automatic report_error(input string what, input int got, input int want);
        error_count++;
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TARGET:    cfg_shadow.target_value   = value[15:0];
            REG_MAX_OUT:   cfg_shadow.max_output     = value[14:0];
            REG_INT_LIMIT: cfg_shadow.integral_limit = value[14:0];
            REG_GAIN_P:    cfg_shadow.gain_p         = value[15:0];
            REG_GAIN_I:    cfg_shadow.gain_i         = value[15:0];
            REG_GAIN_D:    cfg_shadow.gain_d         = value[15:0];
            REG_LOOP_MODE: cfg_shadow.loop_mode      = value[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering samples and wait until every expected drive has arrived.
    task automatic wait_drained();
        meas_if.valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(negedge i_clk);
    endtask

    // Registers change only while the controller is idle.
    task automatic set_config(input logic [31:0] target, input logic [31:0] maxo,
                              input logic [31:0] ilim, input logic [31:0] gp,
                              input logic [31:0] gi, input logic [31:0] gd,
                              input logic [31:0] mode);
        wait_drained();
        write_reg(REG_TARGET, target);
        write_reg(REG_MAX_OUT, maxo);
        write_reg(REG_INT_LIMIT, ilim);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_LOOP_MODE, mode);
    endtask

    // Offer one sample and record its expected drive once accepted.
    // Valid stays high on return so that a following sample may go back to back.
    task automatic send_measure(input logic signed [15:0] sample);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            meas_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        meas_if.valid   <= 1'b1;
        meas_if.measure <= sample;
        do @(posedge i_clk); while (!meas_if.ready);
        drive_expect_q.push_back(pid_step(sample));
        @(negedge i_clk);
    endtask

    // With all gains at reset the drive is zero whatever the sample.
    task automatic test_reset_values();
        send_measure(16'sh7FFF);
        send_measure(-16'sd32768);
    endtask

    // Extremes of the sample, of the error and of every register.
    task automatic test_extremes();
        set_config(0, 32767, 32767, 256, 0, 0, 32'(MODE_NORMAL));
        send_measure(16'sh7FFF);
        send_measure(-16'sd32768);
        send_measure(16'sd0);
        set_config(32767, 32767, 32767, 256, 0, 0, 32'(MODE_NORMAL));
        send_measure(-16'sd32768);
        set_config(-32768, 32767, 32767, 256, 0, 0, 32'(MODE_NORMAL));
        send_measure(16'sh7FFF);
        set_config(-32768, 0, 0, -32768, 32767, 32767, 32'(MODE_NORMAL));
        send_measure(16'sh7FFF);
        send_measure(-16'sd32768);
        set_config(123, 1000, 32767, 32767, -32768, -32768, 32'(MODE_NORMAL));
        send_measure(-16'sd32768);
        send_measure(16'sh7FFF);
    endtask

    // Straight mode: errors of magnitude 9 fall inside the deadband, 10 do not.
    task automatic test_deadband();
        set_config(100, 32767, 32767, 256, 16, 256, 32'(MODE_STRAIGHT));
        send_measure(16'sd91);
        send_measure(16'sd109);
        send_measure(16'sd90);
        send_measure(16'sd110);
        send_measure(16'sd100);
    endtask

    // Orientation mode: the derivative is dropped from an error of 40 up.
    task automatic test_orientation_gate();
        set_config(0, 32767, 32767, 256, 0, 512, 32'(MODE_ORIENT));
        send_measure(-16'sd39);
        send_measure(-16'sd40);
        send_measure(16'sd100);
        send_measure(-16'sd1000);
        send_measure(-16'sd41);
    endtask

    // Negative sums round toward zero; a tiny limit pins the integral.
    task automatic test_truncation_and_clamp();
        set_config(0, 32767, 5, 128, 32767, 0, 32'(MODE_NORMAL));
        send_measure(16'sd3);
        send_measure(-16'sd3);
        send_measure(-16'sd3);
        send_measure(16'sd1);
    endtask

    // The spare mode code acts as normal mode; a write past the map is ignored.
    task automatic test_unused_mode_and_bad_index();
        set_config(50, 32767, 32767, 256, 0, 256, 32'(MODE_UNUSED));
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_measure(16'sd0);
        send_measure(-16'sd40);
    endtask

    // The drive side holds off while samples keep coming, so the pipeline
    // fills and the measurement channel must stall.
    task automatic test_backpressure();
        set_config(0, 32767, 32767, 64, 8, 32, 32'(MODE_NORMAL));
        no_idle     = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (BURST_SAMPLES) send_measure(pick_measure());
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Random register sets, with junk in the unused upper data bits.
    task automatic test_random();
        logic [31:0] junk;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            junk = $urandom();
            set_config({junk[31:16], pick_target()}, {junk[31:15], pick_limit()},
                       {junk[31:15], pick_limit()}, {junk[31:16], pick_gain()},
                       {junk[31:16], pick_gain()}, {junk[31:16], pick_gain()},
                       {junk[31:2], 2'($urandom_range(0, 3))});
            no_idle = (phase % 4 == 2);
            repeat (PHASE_SAMPLES) send_measure(pick_measure());
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Drive side ready: a forced hold-off first, then random stalls.
    initial begin : drive_sink
        int   stall_left;
        logic ready_next;
        stall_left     = 0;
        drive_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
            drive_if.ready <= ready_next;
        end
    end

    // Check each drive transaction against the oldest expected value.
    always @(posedge i_clk) begin : check_drive
        logic signed [15:0] expected;
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            if (drive_expect_q.size() == 0) begin
                report_error("drive transaction with no sample pending",
                             int'(drive_if.drive), 0);
            end else begin
                expected = drive_expect_q.pop_front();
                if (drive_if.drive !== expected) begin
                    report_error("drive mismatch", int'(drive_if.drive), int'(expected));
                end
            end
        end
    end

    // Ends the run when no transaction of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((meas_if.valid && meas_if.ready) || (drive_if.valid && drive_if.ready) ||
                    (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : run_tests
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        meas_if.valid   = 1'b0;
        meas_if.measure = '0;
        error_count     = 0;
        no_idle         = 1'b0;
        hold_cycles     = 0;
        last_error      = '0;
        integral_acc    = '0;
        cfg_shadow.target_value   = '0;
        cfg_shadow.max_output     = MAX_OUT_RESET;
        cfg_shadow.integral_limit = INT_LIMIT_RESET;
        cfg_shadow.gain_p         = '0;
        cfg_shadow.gain_i         = '0;
        cfg_shadow.gain_d         = '0;
        cfg_shadow.loop_mode      = MODE_NORMAL;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_extremes();
        test_deadband();
        test_orientation_gate();
        test_truncation_and_clamp();
        test_unused_mode_and_bad_index();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
